[rtl/spectrum_average_variance_accumulator_top_defines.svh]
// Assertion macros shared by the checker of the spectrum averaging block.
`ifndef SPECTRUM_AVERAGE_VARIANCE_ACCUMULATOR_TOP_DEFINES_SVH
`define SPECTRUM_AVERAGE_VARIANCE_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SAVA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sava check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SAVA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sava check failed");

`endif

[rtl/sava_pkg.sv]
// Types and constants of the spectrum averaging and variance block.
package sava_pkg;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_FRAC = 1'b1;

  localparam logic [15:0] RST_ACC_SIZE = 16'd10;
  localparam logic [16:0] RST_AVG_FRAC = 17'd6554;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [15:0] SLICE_MAX    = 16'hFFFF;
  localparam logic [55:0] MEAN_MAX     = 56'hFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SQ_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] OUT_MEAN_MAX = 64'h0000_00FF_FFFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic        channel;
    logic [9:0]  bin_index;
    logic [23:0] sample_value;
    logic        end_of_slice;
  } in_req_t;

  typedef struct packed {
    logic [39:0] mean_value;
    logic [47:0] variance_value;
    logic        no_data;
  } out_req_t;

endpackage

[rtl/spectrum_average_variance_accumulator_top.sv]
// Top level of the per-bin spectrum averaging and variance block.
//
// The block keeps, for every channel and frequency bin, a running mean of the
// bin power and a running mean of its square, held in two on-chip memories of
// CHANNELS*BINS entries. An accumulate request blends its power value into both
// memories; a readout request returns the bin mean (Q24.16), the variance
// (mean of squares minus squared mean, clamped at zero) and a no_data flag.
// The datapath is a 13-stage pipeline that takes one request per clock while
// in_stall_o is low. An accumulate reads the memories when it is accepted and
// writes them back as it leaves the third stage; a request to a bin that an
// accumulate in flight still has to write is held off by in_stall_o until
// that write lands. A readout passes through every stage and waits in the
// output register of the last one until the receiver takes it; most of the
// pipeline depth is a radix-256 divider (eight stages) that divides by the
// slice count in sum mode. After reset the block clears all CHANNELS*BINS
// entries of both memories (2048 at the default size), one entry per cycle,
// and accepts no request until that pass is done; configuration writes are
// taken at any time. The output register lets the pipeline keep accepting
// while a finished result waits for out_stall_i.
module spectrum_average_variance_accumulator_top #(
  parameter int unsigned BINS     = 1024,
  parameter int unsigned CHANNELS = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sava_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sava_pkg::out_req_t                  out_req_o,
  input  logic                                cfg_we_i,
  input  logic [sava_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sava_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import sava_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LAST  = 12;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // One radix-256 step of a restoring divider: eight quotient bits.
  function automatic logic [79:0] div8(input logic [15:0] rem, input logic [63:0] dq,
                                       input logic [15:0] dvs);
    logic [16:0] r;
    logic [15:0] rr;
    logic [63:0] q;
    rr = rem;
    q  = dq;
    for (int i = 0; i < 8; i++) begin
      r = {rr, q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
      rr = r[15:0];
    end
    return {rr, q};
  endfunction

  // Configuration and slice counter.
  logic [15:0] acc_size_q;
  logic [16:0] avg_frac_q;
  logic [15:0] scount_q;

  // Memory clearing pass.
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  // Stage valids and the ready chain.
  logic [LAST:0] v_q;
  logic [LAST:0] free;

  // Stage 0: accepted request plus the memory read data.
  logic [23:0]   s0_x_q;
  logic [16:0]   s0_frac_q, s0_keep_q;
  logic [AW-1:0] s0_idx_q;
  logic          s0_wr_q, s0_rd_q;
  logic [55:0]   rdm_q;
  logic [63:0]   rds_q;

  // Stage 1: first products.
  logic [47:0]   s1_xx_q;
  logic [40:0]   s1_xm_q;
  logic [55:0]   s1_mkhi_q;
  logic [16:0]   s1_mklo_q;
  logic [63:0]   s1_skhi_q;
  logic [16:0]   s1_sklo_q;
  logic [16:0]   s1_frac_q;
  logic [AW-1:0] s1_idx_q;
  logic          s1_wr_q, s1_rd_q;

  // Stage 2: scaled old values and the new-sample terms.
  logic [55:0]   s2_mb_q;
  logic [63:0]   s2_sb_q;
  logic [40:0]   s2_ma_q;
  logic [63:0]   s2_sa_q;
  logic [AW-1:0] s2_idx_q;
  logic          s2_wr_q, s2_rd_q;

  // Readout side: divider stages 1 to 8, then the variance stages.
  logic          nd_q  [0:LAST-1];
  logic [15:0]   dv_q  [0:8];
  logic [63:0]   dm_q  [1:8];
  logic [15:0]   rm_q  [1:8];
  logic [63:0]   ds_q  [1:8];
  logic [15:0]   rs_q  [1:8];
  logic [63:0]   dm_in [1:8];
  logic [15:0]   rm_in [1:8];
  logic [63:0]   ds_in [1:8];
  logic [15:0]   rs_in [1:8];
  logic [39:0]   p9_m_q, p10_m_q;
  logic [63:0]   p9_s_q, p10_s_q, p11_s_q;
  logic [47:0]   p10_aa_q;
  logic [39:0]   p10_ab_q;
  logic [31:0]   p10_bb_q;
  logic [63:0]   p11_msq_q;
  logic [39:0]   p11_m_q;
  out_req_t      out_q;

  // Memories.
  logic [55:0]   mem_m [0:DEPTH-1];
  logic [63:0]   mem_s [0:DEPTH-1];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [55:0]   mem_wm;
  logic [63:0]   mem_ws;

  // Input decode.
  logic [31:0]   idx_full;
  logic          addr_ok, in_fire, hazard, is_acc, sum_mode, warm, nodata_c;
  logic [AW-1:0] in_idx;
  logic [16:0]   frac_c, frac_eff, keep_c;
  logic [15:0]   divisor_c;

  // Commit arithmetic.
  logic [56:0]   m_sum;
  logic [64:0]   s_sum;
  logic          commit;

  assign idx_full = 32'(in_req_i.channel) * 32'(BINS) + 32'(in_req_i.bin_index);
  assign addr_ok  = (32'(in_req_i.channel) < 32'(CHANNELS)) &&
                    (32'(in_req_i.bin_index) < 32'(BINS));
  assign in_idx   = addr_ok ? idx_full[AW-1:0] : '0;
  assign is_acc   = (in_req_i.cmd == CMD_ACCUM);

  assign sum_mode  = (acc_size_q == 16'd0);
  assign warm      = (scount_q < acc_size_q);
  assign frac_c    = (avg_frac_q > ONE_Q16) ? ONE_Q16 : avg_frac_q;
  assign frac_eff  = sum_mode ? ONE_Q16 : frac_c;
  // A keep of one leaves the stored value untouched through the scaling step.
  assign keep_c    = (sum_mode || warm) ? ONE_Q16 : (ONE_Q16 - frac_c);
  assign nodata_c  = !addr_ok || (sum_mode && (scount_q == 16'd0));
  // Outside sum mode the divider divides by one.
  assign divisor_c = sum_mode ? scount_q : 16'd1;

  // A request may not read a bin that an older accumulate has yet to write.
  assign hazard = (v_q[0] && s0_wr_q && (s0_idx_q == in_idx)) ||
                  (v_q[1] && s1_wr_q && (s1_idx_q == in_idx)) ||
                  (v_q[2] && s2_wr_q && (s2_idx_q == in_idx));

  always_comb begin
    free[LAST] = !v_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k+1];
    end
  end

  assign in_stall_o = !free[0] || clr_q || hazard;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Write-back as the accumulate leaves stage 2, saturating at full scale.
  assign m_sum  = {1'b0, s2_mb_q} + {16'b0, s2_ma_q};
  assign s_sum  = {1'b0, s2_sb_q} + {1'b0, s2_sa_q};
  assign commit = v_q[2] && s2_wr_q && free[3];

  always_comb begin
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wm    = '0;
      mem_ws    = '0;
    end else begin
      mem_we    = commit;
      mem_waddr = s2_idx_q;
      mem_wm    = m_sum[56] ? MEAN_MAX : m_sum[55:0];
      mem_ws    = s_sum[64] ? SQ_MAX : s_sum[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_m[mem_waddr] <= mem_wm;
      mem_s[mem_waddr] <= mem_ws;
    end
    if (in_fire) begin
      rdm_q <= mem_m[in_idx];
      rds_q <= mem_s[in_idx];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_size_q <= RST_ACC_SIZE;
      avg_frac_q <= RST_AVG_FRAC;
      scount_q   <= '0;
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      v_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACC_SIZE: acc_size_q <= cfg_wdata_i[15:0];
          CFG_AVG_FRAC: avg_frac_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_fire && is_acc && in_req_i.end_of_slice && (scount_q != SLICE_MAX)) begin
        scount_q <= scount_q + 16'd1;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == LAST_IDX) begin
          clr_q <= 1'b0;
        end
      end
      if (free[0]) begin
        v_q[0] <= in_fire;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (free[k]) begin
          // Accumulates end at stage 2; only readouts go further.
          v_q[k] <= (k == 3) ? (v_q[2] && s2_rd_q) : v_q[k-1];
        end
      end
    end
  end

  // Stage 0.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_x_q    <= in_req_i.sample_value;
      s0_frac_q <= frac_eff;
      s0_keep_q <= keep_c;
      s0_idx_q  <= in_idx;
      s0_wr_q   <= is_acc && addr_ok;
      s0_rd_q   <= !is_acc;
      nd_q[0]   <= nodata_c;
      dv_q[0]   <= divisor_c;
    end
  end

  // Stage 1.
  always_ff @(posedge clk_i) begin
    if (free[1]) begin
      s1_xx_q   <= {24'b0, s0_x_q} * {24'b0, s0_x_q};
      s1_xm_q   <= {17'b0, s0_x_q} * {24'b0, s0_frac_q};
      s1_mkhi_q <= 56'({17'b0, rdm_q[55:16]} * {40'b0, s0_keep_q});
      s1_mklo_q <= 17'(({17'b0, rdm_q[15:0]} * {16'b0, s0_keep_q}) >> 16);
      s1_skhi_q <= 64'({17'b0, rds_q[63:16]} * {48'b0, s0_keep_q});
      s1_sklo_q <= 17'(({17'b0, rds_q[15:0]} * {16'b0, s0_keep_q}) >> 16);
      s1_frac_q <= s0_frac_q;
      s1_idx_q  <= s0_idx_q;
      s1_wr_q   <= s0_wr_q;
      s1_rd_q   <= s0_rd_q;
    end
  end

  // Stage 2.
  always_ff @(posedge clk_i) begin
    if (free[2]) begin
      s2_mb_q  <= s1_mkhi_q + {39'b0, s1_mklo_q};
      s2_sb_q  <= s1_skhi_q + {47'b0, s1_sklo_q};
      s2_ma_q  <= s1_xm_q;
      s2_sa_q  <= 64'({17'b0, s1_xx_q} * {48'b0, s1_frac_q});
      s2_idx_q <= s1_idx_q;
      s2_wr_q  <= s1_wr_q;
      s2_rd_q  <= s1_rd_q;
    end
  end

  // Divider: mean and mean of squares divided by the same divisor.
  always_comb begin
    dm_in[1] = {8'b0, rdm_q};
    rm_in[1] = '0;
    ds_in[1] = rds_q;
    rs_in[1] = '0;
    for (int k = 2; k <= 8; k++) begin
      dm_in[k] = dm_q[k-1];
      rm_in[k] = rm_q[k-1];
      ds_in[k] = ds_q[k-1];
      rs_in[k] = rs_q[k-1];
    end
  end

  for (genvar k = 1; k <= 8; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (free[k]) begin
        {rm_q[k], dm_q[k]} <= div8(rm_in[k], dm_in[k], dv_q[k-1]);
        {rs_q[k], ds_q[k]} <= div8(rs_in[k], ds_in[k], dv_q[k-1]);
        dv_q[k]            <= dv_q[k-1];
        nd_q[k]            <= nd_q[k-1];
      end
    end
  end

  // Variance stages.
  always_ff @(posedge clk_i) begin
    if (free[9]) begin
      p9_m_q  <= (dm_q[8] > OUT_MEAN_MAX) ? OUT_MEAN_MAX[39:0] : dm_q[8][39:0];
      p9_s_q  <= ds_q[8];
      nd_q[9] <= nd_q[8];
    end
    if (free[10]) begin
      p10_aa_q <= {24'b0, p9_m_q[39:16]} * {24'b0, p9_m_q[39:16]};
      p10_ab_q <= {16'b0, p9_m_q[39:16]} * {24'b0, p9_m_q[15:0]};
      p10_bb_q <= {16'b0, p9_m_q[15:0]} * {16'b0, p9_m_q[15:0]};
      p10_m_q  <= p9_m_q;
      p10_s_q  <= p9_s_q;
      nd_q[10] <= nd_q[9];
    end
    if (free[11]) begin
      // Squared mean in Q.16; it never exceeds 64 bits for a 40-bit mean.
      p11_msq_q <= {p10_aa_q, 16'b0} + {23'b0, p10_ab_q, 1'b0} + {48'b0, p10_bb_q[31:16]};
      p11_m_q   <= p10_m_q;
      p11_s_q   <= p10_s_q;
      nd_q[11]  <= nd_q[10];
    end
    if (free[12]) begin
      if (nd_q[11]) begin
        out_q.mean_value     <= '0;
        out_q.variance_value <= '0;
        out_q.no_data        <= 1'b1;
      end else begin
        out_q.mean_value     <= p11_m_q;
        out_q.variance_value <= (p11_s_q > p11_msq_q) ? 48'((p11_s_q - p11_msq_q) >> 16)
                                                      : 48'd0;
        out_q.no_data        <= 1'b0;
      end
    end
  end

  assign out_valid_o = v_q[LAST];
  assign out_req_o   = out_q;

endmodule

[rtl/sava_checker.sv]
// Port-level checker of the spectrum averaging block and its bind.
`include "spectrum_average_variance_accumulator_top_defines.svh"

module sava_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input sava_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sava_pkg::out_req_t out_req_o
);
  import sava_pkg::*;

  logic out_held, in_held, nodata_seen, zero_vals;

  assign out_held    = out_valid_o && out_stall_i;
  assign in_held     = in_valid_i && in_stall_o;
  assign nodata_seen = out_valid_o && out_req_o.no_data;
  assign zero_vals   = (out_req_o.mean_value == 40'd0) && (out_req_o.variance_value == 48'd0);

  // A result held back by the receiver stays put.
  `SAVA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_req_o))

  // A request held off by the block stays put.
  `SAVA_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i && $stable(in_req_i))

  // An empty readout carries zero values.
  `SAVA_ASSERT_IMP(a_nodata_zero, clk_i, rst_ni, nodata_seen, zero_vals)

  // The memory clearing pass holds off requests right after reset.
  `SAVA_ASSERT_IMP(a_clear_stall, clk_i, rst_ni, $rose(rst_ni), in_stall_o)

endmodule

bind spectrum_average_variance_accumulator_top sava_checker u_sava_checker (.*);
